// ===== rtl/core/isp_pkg.sv =====
// Shared types and constants for the inductor steering PD core.
// No dependencies; every other file of the core imports this package.
`default_nettype none

package isp_pkg;

  // Field widths
  localparam int unsigned SENSOR_W = 12;
  localparam int unsigned SUM_W    = SENSOR_W + 1;
  localparam int unsigned GAIN_W   = 10;
  localparam int unsigned ERR_W    = 16;
  localparam int unsigned DRIVE_W  = 17;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned CFG_W    = 12;
  localparam int unsigned CFG_IDX_W = 3;

  // Error is Q1.15: one restoring step per fraction bit
  localparam int unsigned FRAC_BITS = ERR_W - 1;

  // Drive has four fraction bits: product scale 2^15 down to 2^4
  localparam int unsigned DRIVE_SHIFT = FRAC_BITS - 4;
  // kp*e + kd*(e - e_old) stays inside +/-2^27
  localparam int unsigned ACC_W = 28;

  // Ring mode codes as seen on the result word
  localparam logic [MODE_W-1:0] MODE_NONE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RIGHT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LEFT  = 2'd2;

  typedef logic [SENSOR_W-1:0] sensor_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RING_ENABLE      = 3'd0,
    REG_KP_GAIN          = 3'd1,
    REG_KD_GAIN          = 3'd2,
    REG_SINGLE_THRESHOLD = 3'd3,
    REG_SIDE_THRESHOLD   = 3'd4,
    REG_EXIT_THRESHOLD   = 3'd5,
    REG_FLOOR_VALUE      = 3'd6,
    REG_FORCED_VALUE     = 3'd7
  } cfg_reg_t;

  // Reset values of the configuration registers
  localparam logic              RST_RING_ENABLE = 1'b1;
  localparam logic [GAIN_W-1:0] RST_KP_GAIN     = 10'd400;
  localparam logic [GAIN_W-1:0] RST_KD_GAIN     = 10'd200;
  localparam sensor_t           RST_SINGLE_TH   = 12'd300;
  localparam sensor_t           RST_SIDE_TH     = 12'd350;
  localparam sensor_t           RST_EXIT_TH     = 12'd70;
  localparam sensor_t           RST_FLOOR       = 12'd5;
  localparam sensor_t           RST_FORCED      = 12'd50;

  typedef struct packed {
    logic              ring_enable;
    logic [GAIN_W-1:0] kp_gain;
    logic [GAIN_W-1:0] kd_gain;
    sensor_t           single_threshold;
    sensor_t           side_threshold;
    sensor_t           exit_threshold;
    sensor_t           floor_value;
    sensor_t           forced_value;
  } cfg_t;

  // Operands handed from the front end to the divider
  typedef struct packed {
    sensor_t          diff;
    logic [SUM_W-1:0] sum;
    logic             neg;
  } div_req_t;

endpackage

`default_nettype wire

// ===== rtl/core/isp_ifs.sv =====
// Valid/ready channel interfaces for sample words and result words.
// Depends on isp_pkg for the field types.
`default_nettype none

interface isp_sample_if import isp_pkg::*;;
  logic    valid;
  logic    ready;
  sensor_t sensor_left_outer;
  sensor_t sensor_left_inner;
  sensor_t sensor_right_inner;
  sensor_t sensor_right_outer;

  modport source (
    output valid, sensor_left_outer, sensor_left_inner,
           sensor_right_inner, sensor_right_outer,
    input  ready
  );
  modport sink (
    input  valid, sensor_left_outer, sensor_left_inner,
           sensor_right_inner, sensor_right_outer,
    output ready
  );
endinterface

interface isp_result_if import isp_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] steer_drive;
  logic signed [ERR_W-1:0]   error_ratio;
  logic [MODE_W-1:0]         ring_mode;

  modport source (
    output valid, steer_drive, error_ratio, ring_mode,
    input  ready
  );
  modport sink (
    input  valid, steer_drive, error_ratio, ring_mode,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/isp_front.sv =====
// Ring tracking, outer-sensor substitution and floor; builds divider operands.
// Depends on isp_pkg.
`default_nettype none

module isp_front import isp_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cfg_t          cfg,
  input  wire logic          accept,
  input  wire sensor_t       s0,
  input  wire sensor_t       s1,
  input  wire sensor_t       s2,
  input  wire sensor_t       s3,
  output div_req_t           req,
  output logic [MODE_W-1:0]  mode_next
);

  typedef enum logic [2:0] {
    R_NONE  = 3'b001,
    R_RIGHT = 3'b010,
    R_LEFT  = 3'b100
  } ring_t;

  ring_t   ring_state;
  ring_t   ring_state_next;
  sensor_t outer_l;
  sensor_t outer_r;
  sensor_t a;
  sensor_t b;
  logic    left_only;
  logic    right_only;

  // Entry pattern: one outer sensor high, the other three low
  assign left_only  = (s0 > cfg.single_threshold) && (s1 < cfg.single_threshold)
                   && (s2 < cfg.single_threshold) && (s3 < cfg.single_threshold);
  assign right_only = (s3 > cfg.single_threshold) && (s1 < cfg.single_threshold)
                   && (s2 < cfg.single_threshold) && (s0 < cfg.single_threshold);

  // Entry first, then exit; substitute on the resulting state
  always_comb begin
    ring_state_next = ring_state;
    outer_l         = s0;
    outer_r         = s3;
    if (cfg.ring_enable) begin
      if ((left_only || right_only) && ring_state == R_NONE) begin
        if (s1 > cfg.side_threshold) begin
          ring_state_next = R_RIGHT;
        end else if (s2 > cfg.side_threshold) begin
          ring_state_next = R_LEFT;
        end
      end
      if (ring_state_next != R_NONE && s0 < cfg.exit_threshold
          && s1 < cfg.exit_threshold) begin
        ring_state_next = R_NONE;
      end
      if (ring_state_next == R_RIGHT) begin
        outer_l = cfg.forced_value;
      end else if (ring_state_next == R_LEFT) begin
        outer_r = cfg.forced_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_state <= R_NONE;
    end else if (accept) begin
      ring_state <= ring_state_next;
    end
  end

  // Map the ring state onto its result code
  always_comb begin
    case (ring_state_next)
      R_RIGHT: mode_next = MODE_RIGHT;
      R_LEFT:  mode_next = MODE_LEFT;
      default: mode_next = MODE_NONE;
    endcase
  end

  // Raise the outer pair to the floor, then form |a-b| and a+b
  assign a = (outer_l < cfg.floor_value) ? cfg.floor_value : outer_l;
  assign b = (outer_r < cfg.floor_value) ? cfg.floor_value : outer_r;

  assign req.neg  = (a < b);
  assign req.diff = (a < b) ? (b - a) : (a - b);
  assign req.sum  = {1'b0, a} + {1'b0, b};

endmodule

`default_nettype wire

// ===== rtl/core/isp_div.sv =====
// Bit-serial restoring divider: |a-b| * 2^15 / (a+b), one quotient bit a cycle.
// Depends on isp_pkg.
`default_nettype none

module isp_div import isp_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire div_req_t           req,
  output logic                    done,
  output logic signed [ERR_W-1:0] err
);

  localparam int unsigned CNT_W = $clog2(FRAC_BITS);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [SUM_W-1:0] divisor;
  logic [SUM_W-1:0] rem;
  logic [ERR_W-1:0] quo;
  logic             neg;
  logic             zero;
  logic [SUM_W:0]   rem_dbl;
  logic             take;
  logic             q_top;

  // Integer part of the quotient is one only when diff equals sum
  assign q_top   = ({1'b0, req.diff} >= req.sum);
  assign rem_dbl = {rem, 1'b0};
  assign take    = (rem_dbl >= {1'b0, divisor});

  // Control: count fraction steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(FRAC_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  // Datapath: shift remainder, subtract when it fits, shift in quotient bit
  always_ff @(posedge clk) begin
    if (start) begin
      divisor <= req.sum;
      neg     <= req.neg;
      zero    <= (req.sum == '0);
      quo     <= {{(ERR_W-1){1'b0}}, q_top};
      rem     <= q_top ? ({1'b0, req.diff} - req.sum) : {1'b0, req.diff};
    end else if (busy) begin
      quo <= {quo[ERR_W-2:0], take};
      rem <= take ? SUM_W'(rem_dbl - {1'b0, divisor}) : rem_dbl[SUM_W-1:0];
    end
  end

  // Sign and clamp: +1.0 saturates, -1.0 is representable
  always_comb begin
    if (zero) begin
      err = '0;
    end else if (neg) begin
      err = -$signed(quo);
    end else if (quo[ERR_W-1]) begin
      err = {1'b0, {(ERR_W-1){1'b1}}};
    end else begin
      err = $signed(quo);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/isp_pd.sv =====
// Error history line and shift-and-add PD multiplier, one gain bit a cycle.
// Depends on isp_pkg.
`default_nettype none

module isp_pd import isp_pkg::*; #(
  parameter int unsigned HISTORY_LAG = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic signed [ERR_W-1:0] err,
  input  wire logic [GAIN_W-1:0]     kp_gain,
  input  wire logic [GAIN_W-1:0]     kd_gain,
  output logic                       done,
  output logic signed [DRIVE_W-1:0]  drive
);

  localparam int unsigned CNT_W = $clog2(GAIN_W);

  logic signed [ERR_W-1:0] hist [HISTORY_LAG];
  logic                    busy;
  logic [CNT_W-1:0]        cnt;
  logic [GAIN_W-1:0]       kp_sh;
  logic [GAIN_W-1:0]       kd_sh;
  logic signed [ERR_W-1:0] e;
  logic signed [ERR_W:0]   d;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_next;

  // Delay line: the last tap is the error HISTORY_LAG words back
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HISTORY_LAG; i++) begin
        hist[i] <= '0;
      end
    end else if (start) begin
      hist[0] <= err;
      for (int i = 1; i < HISTORY_LAG; i++) begin
        hist[i] <= hist[i-1];
      end
    end
  end

  // Control: one step per gain bit
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(GAIN_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  // Double the sum, add each multiplicand where its gain bit is set, MSB first
  always_comb begin
    acc_next = (acc <<< 1);
    if (kp_sh[GAIN_W-1]) begin
      acc_next = acc_next + ACC_W'(e);
    end
    if (kd_sh[GAIN_W-1]) begin
      acc_next = acc_next + ACC_W'(d);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      e     <= err;
      d     <= (ERR_W+1)'(err) - (ERR_W+1)'(hist[HISTORY_LAG-1]);
      kp_sh <= kp_gain;
      kd_sh <= kd_gain;
      acc   <= '0;
    end else if (busy) begin
      kp_sh <= {kp_sh[GAIN_W-2:0], 1'b0};
      kd_sh <= {kd_sh[GAIN_W-2:0], 1'b0};
      acc   <= acc_next;
    end
  end

  // Arithmetic shift floors; the sum's bound keeps it inside 17 bits
  assign drive = acc[ACC_W-1:DRIVE_SHIFT];

endmodule

`default_nettype wire

// ===== rtl/core/inductor_steering_pd_core.sv =====
// Steering core: ring handling, difference-over-sum error and PD drive.
// Depends on isp_pkg, isp_ifs, isp_front, isp_div and isp_pd.
//
// Takes one sample word of four 12-bit inductor readings and returns one
// result word: the Q1.15 error of the outer pair, the PD drive with four
// fraction bits and the ring mode. From acceptance a word goes through the
// bit-serial restoring divider, a hand-off, the shift-and-add multiplier,
// the raising of the result word and its read, and a return to idle
// before the next sample word is taken; while ready stays low the result
// word waits. One word is in flight at a time, and the next is taken once
// the result has been read. Configuration writes land on the edge where
// cfg_we is high and must come while the core is idle.
`default_nettype none

module inductor_steering_pd_core import isp_pkg::*; #(
  parameter int unsigned HISTORY_LAG = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  isp_sample_if.sink                sample,
  isp_result_if.source              result
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_PD   = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t                    state;
  state_t                    state_next;
  cfg_t                      cfg;
  div_req_t                  req;
  logic [MODE_W-1:0]         mode_next;
  logic [MODE_W-1:0]         ring_mode;
  logic                      accept;
  logic                      div_done;
  logic                      pd_start;
  logic                      pd_done;
  logic signed [ERR_W-1:0]   err;
  logic signed [DRIVE_W-1:0] drive;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ring_enable      <= RST_RING_ENABLE;
      cfg.kp_gain          <= RST_KP_GAIN;
      cfg.kd_gain          <= RST_KD_GAIN;
      cfg.single_threshold <= RST_SINGLE_TH;
      cfg.side_threshold   <= RST_SIDE_TH;
      cfg.exit_threshold   <= RST_EXIT_TH;
      cfg.floor_value      <= RST_FLOOR;
      cfg.forced_value     <= RST_FORCED;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_RING_ENABLE:      cfg.ring_enable      <= cfg_data[0];
        REG_KP_GAIN:          cfg.kp_gain          <= cfg_data[GAIN_W-1:0];
        REG_KD_GAIN:          cfg.kd_gain          <= cfg_data[GAIN_W-1:0];
        REG_SINGLE_THRESHOLD: cfg.single_threshold <= cfg_data[SENSOR_W-1:0];
        REG_SIDE_THRESHOLD:   cfg.side_threshold   <= cfg_data[SENSOR_W-1:0];
        REG_EXIT_THRESHOLD:   cfg.exit_threshold   <= cfg_data[SENSOR_W-1:0];
        REG_FLOOR_VALUE:      cfg.floor_value      <= cfg_data[SENSOR_W-1:0];
        REG_FORCED_VALUE:     cfg.forced_value     <= cfg_data[SENSOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: accept, divide, multiply, present
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_DIV;
      S_DIV:   if (div_done) state_next = S_PD;
      S_PD:    if (pd_done) state_next = S_OUT;
      S_OUT:   if (result.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign sample.ready = (state == S_IDLE);
  assign accept       = sample.valid && sample.ready;
  assign pd_start     = (state == S_DIV) && div_done;

  // Hold the ring mode of the word in flight
  always_ff @(posedge clk) begin
    if (accept) begin
      ring_mode <= mode_next;
    end
  end

  isp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .s0        (sample.sensor_left_outer),
    .s1        (sample.sensor_left_inner),
    .s2        (sample.sensor_right_inner),
    .s3        (sample.sensor_right_outer),
    .req       (req),
    .mode_next (mode_next)
  );

  isp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .req   (req),
    .done  (div_done),
    .err   (err)
  );

  isp_pd #(
    .HISTORY_LAG (HISTORY_LAG)
  ) u_pd (
    .clk     (clk),
    .rst     (rst),
    .start   (pd_start),
    .err     (err),
    .kp_gain (cfg.kp_gain),
    .kd_gain (cfg.kd_gain),
    .done    (pd_done),
    .drive   (drive)
  );

  // Result word: held in the unit registers until read
  assign result.valid       = (state == S_OUT);
  assign result.steer_drive = drive;
  assign result.error_ratio = err;
  assign result.ring_mode   = ring_mode;

endmodule

`default_nettype wire

// ===== tb/tb_inductor_steering_pd_core.sv =====
// Self-checking testbench for inductor_steering_pd_core: ring tracking,
// difference-over-sum error and PD drive, checked word by word.
// Depends on isp_pkg, isp_ifs and the core RTL.
`default_nettype none

module tb_inductor_steering_pd_core;
  import isp_pkg::*;

  localparam int HIST_LAG = 4;

  typedef struct packed {
    sensor_t left_outer;
    sensor_t left_inner;
    sensor_t right_inner;
    sensor_t right_outer;
  } sample_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic signed [ERR_W-1:0]   err;
    logic [MODE_W-1:0]         mode;
  } pd_word_t;

  typedef struct {
    bit       is_cfg;
    cfg_reg_t reg_idx;
    int       cfg_val;
    sample_t  smp;
    bit       typed;
    pd_word_t want;
  } step_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  isp_sample_if sample_ch ();
  isp_result_if result_ch ();

  inductor_steering_pd_core #(.HISTORY_LAG(HIST_LAG)) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample_ch),
    .result    (result_ch)
  );

  always #4 clk = ~clk;

  // Shadow of the core: configuration, ring state and error history
  cfg_t        cfg_shadow;
  logic [1:0]  ring_st = MODE_NONE;
  int          err_hist [HIST_LAG] = '{default: 0};
  int          hist_idx = 0;

  pd_word_t    pending_words [$];
  int          mismatch_count = 0;
  int          words_sent = 0;
  int          snd_idle_pct = 8;
  int          rcv_idle_pct = 87;
  step_row_t   dir_tab [$];

  function automatic sample_t mk_sample(int a, int b, int c, int d);
    mk_sample = '{sensor_t'(a), sensor_t'(b), sensor_t'(c), sensor_t'(d)};
  endfunction

  // Expected result word for one accepted sample; advances the shadow state
  function automatic pd_word_t steer_predict(sample_t sv);
    int unsigned v [4];
    int unsigned thr, sum, diff, mag;
    bit lo_pat, ro_pat;
    int e, lagged;
    longint acc, drv;
    pd_word_t w;
    v[0] = sv.left_outer;
    v[1] = sv.left_inner;
    v[2] = sv.right_inner;
    v[3] = sv.right_outer;
    // Ring entry is tested before exit; substitution follows the new state
    if (cfg_shadow.ring_enable) begin
      thr = cfg_shadow.single_threshold;
      lo_pat = v[0] > thr && v[1] < thr && v[2] < thr && v[3] < thr;
      ro_pat = v[3] > thr && v[1] < thr && v[2] < thr && v[0] < thr;
      if ((lo_pat || ro_pat) && ring_st == MODE_NONE) begin
        if (v[1] > cfg_shadow.side_threshold) ring_st = MODE_RIGHT;
        else if (v[2] > cfg_shadow.side_threshold) ring_st = MODE_LEFT;
      end
      if (ring_st != MODE_NONE) begin
        if (v[0] < cfg_shadow.exit_threshold && v[1] < cfg_shadow.exit_threshold)
          ring_st = MODE_NONE;
        if (ring_st == MODE_RIGHT) v[0] = cfg_shadow.forced_value;
        else if (ring_st == MODE_LEFT) v[3] = cfg_shadow.forced_value;
      end
    end
    for (int i = 0; i < 4; i++)
      if (v[i] < cfg_shadow.floor_value) v[i] = cfg_shadow.floor_value;
    // Q1.15 ratio, truncated toward zero, +1 clipped
    sum = v[0] + v[3];
    if (sum == 0) begin
      e = 0;
    end else begin
      diff = (v[0] >= v[3]) ? v[0] - v[3] : v[3] - v[0];
      mag = diff * 32768 / sum;
      if (v[0] >= v[3]) e = (mag > 32767) ? 32767 : int'(mag);
      else e = -int'(mag);
    end
    lagged = err_hist[hist_idx];
    err_hist[hist_idx] = e;
    hist_idx = (hist_idx + 1 >= HIST_LAG) ? 0 : hist_idx + 1;
    // PD sum, floored to four fraction bits, clipped to 17 bits
    acc = longint'(cfg_shadow.kp_gain) * e + longint'(cfg_shadow.kd_gain) * (e - lagged);
    drv = acc >>> 11;
    if (drv > 65535) drv = 65535;
    if (drv < -65536) drv = -65536;
    w.drive = drv[DRIVE_W-1:0];
    w.err = e[ERR_W-1:0];
    w.mode = ring_st;
    return w;
  endfunction

  function automatic step_row_t cfg_row(cfg_reg_t idx, int val);
    cfg_row = '{1'b1, idx, val, '0, 1'b0, '0};
  endfunction

  function automatic step_row_t smp_row(int a, int b, int c, int d);
    smp_row = '{1'b0, REG_RING_ENABLE, 0, mk_sample(a, b, c, d), 1'b0, '0};
  endfunction

  function automatic step_row_t chk_row(int a, int b, int c, int d,
                                        int drv, int er, logic [1:0] md);
    chk_row = '{1'b0, REG_RING_ENABLE, 0, mk_sample(a, b, c, d), 1'b1,
                '{DRIVE_W'(drv), ERR_W'(er), md}};
  endfunction

  function automatic int below(int t);
    below = (t <= 0) ? 0 : int'($urandom_range(t - 1, 0));
  endfunction

  function automatic int above(int t);
    above = (t >= 4095) ? 4095 : int'($urandom_range(4095, t + 1));
  endfunction

  function automatic int near(int v);
    int x;
    x = v - 1 + int'($urandom_range(2));
    near = (x < 0) ? 0 : (x > 4095) ? 4095 : x;
  endfunction

  // Write one register at the next edge; caller lowers cfg_we
  task automatic cfg_write(cfg_reg_t idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_RING_ENABLE:      cfg_shadow.ring_enable = val[0];
      REG_KP_GAIN:          cfg_shadow.kp_gain = val[GAIN_W-1:0];
      REG_KD_GAIN:          cfg_shadow.kd_gain = val[GAIN_W-1:0];
      REG_SINGLE_THRESHOLD: cfg_shadow.single_threshold = val;
      REG_SIDE_THRESHOLD:   cfg_shadow.side_threshold = val;
      REG_EXIT_THRESHOLD:   cfg_shadow.exit_threshold = val;
      REG_FLOOR_VALUE:      cfg_shadow.floor_value = val;
      REG_FORCED_VALUE:     cfg_shadow.forced_value = val;
      default: ;
    endcase
  endtask

  // Drop valid and hold until every expected word is back
  task automatic wait_idle();
    sample_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Offer one sample word, with random idle cycles ahead of it
  task automatic send_sample(sample_t sv, bit typed = 1'b0, pd_word_t want = '0);
    pd_word_t w;
    if ($urandom_range(99) < snd_idle_pct) begin
      sample_ch.valid <= 1'b0;
      do begin
        @(posedge clk);
      end while ($urandom_range(99) < snd_idle_pct);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.sensor_left_outer <= sv.left_outer;
    sample_ch.sensor_left_inner <= sv.left_inner;
    sample_ch.sensor_right_inner <= sv.right_inner;
    sample_ch.sensor_right_outer <= sv.right_outer;
    do begin
      @(posedge clk);
    end while (!sample_ch.ready);
    w = steer_predict(sv);
    pending_words.push_back(typed ? want : w);
    words_sent++;
  endtask

  function automatic sample_t rand_sample();
    rand_sample = mk_sample($urandom_range(4095), $urandom_range(4095),
                            $urandom_range(4095), $urandom_range(4095));
  endfunction

  // Program every register for one phase of random traffic
  task automatic program_phase(int ph);
    cfg_t nc;
    nc.ring_enable = 1'b1;
    nc.kp_gain = GAIN_W'($urandom);
    nc.kd_gain = GAIN_W'($urandom);
    nc.single_threshold = SENSOR_W'($urandom_range(1500, 200));
    nc.side_threshold = SENSOR_W'($urandom_range(nc.single_threshold - 2, 0));
    nc.exit_threshold = SENSOR_W'($urandom_range(400, 20));
    nc.floor_value = SENSOR_W'($urandom_range(20, 1));
    nc.forced_value = SENSOR_W'($urandom);
    case (ph)
      1: begin
        nc.kp_gain = 10'd1023;
        nc.kd_gain = 10'd1023;
        nc.single_threshold = 12'd4095;
        nc.side_threshold = 12'd4095;
        nc.exit_threshold = 12'd4095;
        nc.floor_value = 12'd4095;
        nc.forced_value = 12'd4095;
      end
      2: begin
        nc.ring_enable = 1'b0;
        nc.kp_gain = 10'd0;
        nc.kd_gain = 10'd1023;
        nc.single_threshold = 12'd0;
        nc.side_threshold = 12'd0;
        nc.floor_value = 12'd1;
        nc.forced_value = 12'd0;
      end
      3: begin
        nc.floor_value = 12'd1;
        nc.forced_value = 12'd4095;
      end
      4: begin
        nc.kp_gain = 10'd1023;
        nc.kd_gain = 10'd0;
        nc.exit_threshold = 12'd0;
        nc.forced_value = 12'd0;
      end
      default: ;
    endcase
    wait_idle();
    cfg_write(REG_RING_ENABLE, CFG_W'(nc.ring_enable));
    cfg_write(REG_KP_GAIN, CFG_W'(nc.kp_gain));
    cfg_write(REG_KD_GAIN, CFG_W'(nc.kd_gain));
    cfg_write(REG_SINGLE_THRESHOLD, nc.single_threshold);
    cfg_write(REG_SIDE_THRESHOLD, nc.side_threshold);
    cfg_write(REG_EXIT_THRESHOLD, nc.exit_threshold);
    cfg_write(REG_FLOOR_VALUE, nc.floor_value);
    cfg_write(REG_FORCED_VALUE, nc.forced_value);
    cfg_we <= 1'b0;
  endtask

  // Random traffic: mostly ring episodes and random samples, some noise
  task automatic run_traffic(int count);
    int target, k, thr, sd, ex, mid_hi;
    bit right, outer_left;
    target = words_sent + count;
    while (words_sent < target) begin
      thr = cfg_shadow.single_threshold;
      sd = cfg_shadow.side_threshold;
      ex = cfg_shadow.exit_threshold;
      k = $urandom_range(9);
      if ($urandom_range(59) == 0) wait_idle();
      if (k < 4 && cfg_shadow.ring_enable && thr >= sd + 2 && thr < 4095) begin
        // enter, ride the ring a few words, then leave
        right = 1'($urandom_range(1));
        outer_left = 1'($urandom_range(1));
        mid_hi = $urandom_range(thr - 1, sd + 1);
        send_sample(mk_sample(outer_left ? above(thr) : below(thr),
                              right ? mid_hi : int'($urandom_range(sd, 0)),
                              right ? below(thr) : mid_hi,
                              outer_left ? below(thr) : above(thr)));
        repeat ($urandom_range(4)) send_sample(rand_sample());
        send_sample(mk_sample(below(ex), below(ex),
                              $urandom_range(4095), $urandom_range(4095)));
      end else if (k == 4) begin
        send_sample(mk_sample($urandom_range(1) ? 4095 : 0, $urandom_range(1) ? 4095 : 0,
                              $urandom_range(1) ? 4095 : 0, $urandom_range(1) ? 4095 : 0));
      end else if (k == 5) begin
        send_sample(mk_sample(near(thr), near($urandom_range(1) ? sd : ex),
                              near($urandom_range(1) ? sd : thr), near(thr)));
      end else begin
        send_sample(rand_sample());
      end
    end
  endtask

  // Result side: random stalls, compare each word with the oldest expectation
  always @(posedge clk) begin : result_check
    pd_word_t exp_w;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_words.size() == 0) begin
        $error("unexpected result word: steer_drive %0d error_ratio %0d ring_mode %0d",
               result_ch.steer_drive, result_ch.error_ratio, result_ch.ring_mode);
        mismatch_count++;
      end else begin
        exp_w = pending_words.pop_front();
        if (result_ch.steer_drive !== exp_w.drive) begin
          $error("steer_drive: expected %0d, got %0d", exp_w.drive, result_ch.steer_drive);
          mismatch_count++;
        end
        if (result_ch.error_ratio !== exp_w.err) begin
          $error("error_ratio: expected %0d, got %0d", exp_w.err, result_ch.error_ratio);
          mismatch_count++;
        end
        if (result_ch.ring_mode !== exp_w.mode) begin
          $error("ring_mode: expected %0d, got %0d", exp_w.mode, result_ch.ring_mode);
          mismatch_count++;
        end
      end
    end
    result_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // Stimulus
  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sample_ch.valid = 1'b0;
    sample_ch.sensor_left_outer = '0;
    sample_ch.sensor_left_inner = '0;
    sample_ch.sensor_right_inner = '0;
    sample_ch.sensor_right_outer = '0;
    cfg_shadow = '{RST_RING_ENABLE, RST_KP_GAIN, RST_KD_GAIN, RST_SINGLE_TH,
                   RST_SIDE_TH, RST_EXIT_TH, RST_FLOOR, RST_FORCED};

    // Directed steps: reset values, extremes, ring entry and exit, floor of zero
    dir_tab = '{
      chk_row(0, 0, 0, 0, 0, 0, MODE_NONE),
      chk_row(4095, 4095, 4095, 4095, 0, 0, MODE_NONE),
      chk_row(2048, 2048, 2048, 2048, 0, 0, MODE_NONE),
      smp_row(4095, 0, 0, 0),
      smp_row(0, 0, 0, 4095),
      cfg_row(REG_SIDE_THRESHOLD, 100),
      smp_row(1000, 200, 0, 0),       // enter on the right
      smp_row(0, 200, 0, 1000),       // entry pattern ignored while in ring
      smp_row(10, 10, 4095, 4095),    // leave
      smp_row(0, 50, 200, 1000),      // enter left and leave in the same word
      smp_row(0, 80, 200, 1000),      // enter left, right outer forced
      cfg_row(REG_RING_ENABLE, 0),
      smp_row(0, 0, 0, 0),            // ring state held, nothing forced
      cfg_row(REG_RING_ENABLE, 1),
      smp_row(0, 0, 0, 0),
      cfg_row(REG_FLOOR_VALUE, 0),
      smp_row(0, 0, 0, 0),            // zero sum
      smp_row(4095, 0, 0, 0),         // full-scale ratio clips
      smp_row(0, 0, 0, 4095),
      cfg_row(REG_KP_GAIN, 1023),
      cfg_row(REG_KD_GAIN, 1023),
      smp_row(4095, 0, 0, 0),
      smp_row(0, 0, 0, 4095),
      smp_row(4095, 0, 0, 0)
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        wait_idle();
        cfg_write(dir_tab[i].reg_idx, CFG_W'(dir_tab[i].cfg_val));
        cfg_we <= 1'b0;
      end else begin
        send_sample(dir_tab[i].smp, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    // Random phases: slow receiver, then slow sender, then no idling
    for (int ph = 0; ph < 6; ph++) begin
      program_phase(ph);
      snd_idle_pct = (ph < 2) ? 8 : (ph < 4) ? 87 : 0;
      rcv_idle_pct = (ph < 2) ? 87 : (ph < 4) ? 8 : 0;
      run_traffic(150);
    end

    wait_idle();
    repeat (64) @(posedge clk);
    if (mismatch_count == 0 && pending_words.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Hang guard
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
